/* src/blk3_pkg.sv */
// Shared types, constants and mixing functions for the BLAKE3 hash block.
`timescale 1ns / 1ps
package blk3_pkg;

    typedef logic [31:0] t_word;
    typedef t_word [7:0]  t_cv;
    typedef t_word [15:0] t_blk;

    localparam t_cv IV = {32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
                          32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667};

    localparam logic [3:0] PERM [16] = '{4'd2, 4'd6, 4'd3, 4'd10, 4'd7, 4'd0, 4'd4, 4'd13,
                                        4'd1, 4'd11, 4'd12, 4'd5, 4'd9, 4'd14, 4'd15, 4'd8};

    localparam t_word FL_START  = 32'd1;
    localparam t_word FL_END    = 32'd2;
    localparam t_word FL_PARENT = 32'd4;
    localparam t_word FL_ROOT   = 32'd8;

    localparam logic [6:0] BLK_BYTES    = 7'd64;
    localparam logic [3:0] LAST_BLK     = 4'd15;
    localparam logic [2:0] LAST_ROUND   = 3'd6;
    localparam logic [2:0] MAX_BYTES    = 3'd4;
    localparam logic [1:0] LAST_PART    = 2'd3;

    typedef enum logic [1:0] {
        K_FLUSH,
        K_FINAL,
        K_PARENT
    } t_kind;

    typedef struct packed {
        logic       load;
        logic       append;
        logic       start;
        t_kind      kind;
        logic       root;
        logic       commit_blk;
        logic       pop;
        logic       push;
        logic       take_res;
        logic       shift_total;
        logic       clear;
        logic [1:0] part;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic fill_full;
        logic chunk_last_blk;
        logic can_merge;
        logic top_zero;
    } t_stat;

    function automatic t_word rotr16(t_word x);
        return {x[15:0], x[31:16]};
    endfunction

    function automatic t_word rotr12(t_word x);
        return {x[11:0], x[31:12]};
    endfunction

    function automatic t_word rotr8(t_word x);
        return {x[7:0], x[31:8]};
    endfunction

    function automatic t_word rotr7(t_word x);
        return {x[6:0], x[31:7]};
    endfunction

    // G function: returns {d, c, b, a}
    function automatic logic [127:0] g_mix(t_word a, t_word b, t_word c, t_word d,
                                           t_word x, t_word y);
        t_word na, nb, nc, nd;
        na = a + b + x;
        nd = rotr16(d ^ na);
        nc = c + nd;
        nb = rotr12(b ^ nc);
        na = na + nb + y;
        nd = rotr8(nd ^ na);
        nc = nc + nd;
        nb = rotr7(nb ^ nc);
        return {nd, nc, nb, na};
    endfunction

    function automatic t_blk permute(t_blk m);
        t_blk t;
        for (int i = 0; i < 16; i++) begin
            t[i] = m[PERM[i]];
        end
        return t;
    endfunction

endpackage

/* src/blk3_ifs.sv */
// Request channel interfaces for message input and digest output.
`timescale 1ns / 1ps
interface blk3_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] msg_word;
    logic [2:0]  byte_count;
    logic        end_of_message;

    modport source (output valid, output msg_word, output byte_count,
                    output end_of_message, input ready);
    modport sink (input valid, input msg_word, input byte_count,
                  input end_of_message, output ready);
endinterface

interface blk3_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_part;
    logic [1:0]  part_index;
    logic        final_part;
    logic        overflow;

    modport source (output valid, output digest_part, output part_index,
                    output final_part, output overflow, input ready);
    modport sink (input valid, input digest_part, input part_index,
                  input final_part, input overflow, output ready);
endinterface

/* src/blake3_tree_hash.sv */
// Usage: unkeyed BLAKE3-256 over a byte stream packed into 32-bit words.
// Input channel i_in carries msg_word (first byte in bits 7:0), byte_count (0..4)
// and end_of_message; a short count belongs on the last request, and an empty
// message is a last request with zero bytes.
// Output channel o_out returns four requests per message: digest_part holds
// digest bytes 8k..8k+7 little-endian, part_index is k, final_part marks k = 3,
// and overflow flags a message that outgrew the subtree stack (digest invalid).
// Throughput: one request is taken, then its bytes are packed one per cycle
// while no compression is running. Each full 64-byte block goes through the
// shared compression unit (7 rounds, one half round per cycle), and each chunk
// close adds a push plus, per parent node, a stack read and one compression.
// After the last request, its bytes are packed, the final block is compressed
// and a parent compression runs per stacked subtree before part 0 is offered.
// The receiver may stall o_out for any time; parts are held until taken, and no
// new request is taken until the fourth part leaves. The block then returns to
// idle with its buffer, chaining value and stack cleared. Reset clears all
// control state and the block buffer; the subtree stack needs no clearing pass.
`timescale 1ns / 1ps
module blake3_tree_hash #(
    parameter int STACK_DEPTH = 54
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    blk3_in_if.sink           i_in,
    blk3_out_if.source        o_out
);

    blk3_pkg::t_cmd  w_cmd;
    blk3_pkg::t_stat w_stat;

    blk3_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in.valid),
        .i_byte_count     (i_in.byte_count),
        .i_end_of_message (i_in.end_of_message),
        .i_out_ready      (o_out.ready),
        .i_stat           (w_stat),
        .o_in_ready       (i_in.ready),
        .o_out_valid      (o_out.valid),
        .o_part_index     (o_out.part_index),
        .o_final_part     (o_out.final_part),
        .o_cmd            (w_cmd)
    );

    blk3_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_msg_word    (i_in.msg_word),
        .o_stat        (w_stat),
        .o_digest_part (o_out.digest_part),
        .o_overflow    (o_out.overflow)
    );

endmodule

/* src/blk3_dp.sv */
// Datapath: block buffer, chaining value, compression rounds and subtree stack.
`timescale 1ns / 1ps
module blk3_dp #(
    parameter int STACK_DEPTH = 54
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  blk3_pkg::t_cmd     i_cmd,
    input  logic [31:0]        i_msg_word,
    output blk3_pkg::t_stat    o_stat,
    output logic [63:0]        o_digest_part,
    output logic               o_overflow
);

    localparam int TW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    blk3_pkg::t_cv  r_cv;
    blk3_pkg::t_blk r_buf;
    logic [6:0]     r_fill;
    logic [3:0]     r_bic;
    logic [63:0]    r_ctr;
    logic [63:0]    r_total;
    logic [TW-1:0]  r_top;
    logic           r_ovf;
    logic [31:0]    r_word;
    blk3_pkg::t_cv  r_res;
    blk3_pkg::t_cv  r_rd;
    blk3_pkg::t_blk r_v;
    blk3_pkg::t_blk r_m;
    logic [2:0]     r_rnd;
    logic           r_half;
    logic           r_busy;
    logic           r_done;
    blk3_pkg::t_cv  r_stack [STACK_DEPTH];

    blk3_pkg::t_cv  w_result;
    blk3_pkg::t_blk n_v;
    blk3_pkg::t_blk w_init_v;
    blk3_pkg::t_blk w_init_m;
    blk3_pkg::t_word w_byte_sh;
    logic [TW-1:0]  w_top_m1;
    logic           w_full;

    assign w_top_m1  = r_top - 1'b1;
    assign w_full    = (r_top >= TW'(STACK_DEPTH));
    assign w_byte_sh = blk3_pkg::t_word'(r_word[7:0]) << {r_fill[1:0], 3'b000};

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            w_result[i] = r_v[i] ^ r_v[i+8];
        end
    end

    assign o_stat.done           = r_done;
    assign o_stat.fill_full      = (r_fill == blk3_pkg::BLK_BYTES);
    assign o_stat.chunk_last_blk = (r_bic == blk3_pkg::LAST_BLK);
    assign o_stat.can_merge      = !r_total[0] && (r_total != '0) && (r_top != '0);
    assign o_stat.top_zero       = (r_top == '0);

    assign o_digest_part = {r_res[{i_cmd.part, 1'b1}], r_res[{i_cmd.part, 1'b0}]};
    assign o_overflow    = r_ovf;

    // Compression input set-up
    always_comb begin
        blk3_pkg::t_word flags;
        flags = '0;
        for (int i = 0; i < 4; i++) begin
            w_init_v[8+i] = blk3_pkg::IV[i];
        end
        case (i_cmd.kind)
            blk3_pkg::K_PARENT: begin
                for (int i = 0; i < 8; i++) w_init_v[i] = blk3_pkg::IV[i];
                w_init_m     = {r_res, r_rd};
                w_init_v[12] = '0;
                w_init_v[13] = '0;
                w_init_v[14] = 32'(blk3_pkg::BLK_BYTES);
                flags        = blk3_pkg::FL_PARENT | (i_cmd.root ? blk3_pkg::FL_ROOT : '0);
            end
            blk3_pkg::K_FINAL: begin
                for (int i = 0; i < 8; i++) w_init_v[i] = r_cv[i];
                w_init_m     = r_buf;
                w_init_v[12] = r_ctr[31:0];
                w_init_v[13] = r_ctr[63:32];
                w_init_v[14] = 32'(r_fill);
                flags        = blk3_pkg::FL_END;
                if (r_bic == '0) flags = flags | blk3_pkg::FL_START;
                if (r_top == '0) flags = flags | blk3_pkg::FL_ROOT;
            end
            default: begin
                for (int i = 0; i < 8; i++) w_init_v[i] = r_cv[i];
                w_init_m     = r_buf;
                w_init_v[12] = r_ctr[31:0];
                w_init_v[13] = r_ctr[63:32];
                w_init_v[14] = 32'(blk3_pkg::BLK_BYTES);
                if (r_bic == '0) flags = flags | blk3_pkg::FL_START;
                if (r_bic == blk3_pkg::LAST_BLK) flags = flags | blk3_pkg::FL_END;
            end
        endcase
        w_init_v[15] = flags;
    end

    // One half round: four column or four diagonal G functions
    always_comb begin
        logic [127:0] g;
        n_v = r_v;
        for (int i = 0; i < 4; i++) begin
            if (!r_half) begin
                g = blk3_pkg::g_mix(r_v[i], r_v[4+i], r_v[8+i], r_v[12+i],
                                    r_m[2*i], r_m[2*i+1]);
                n_v[i]    = g[31:0];
                n_v[4+i]  = g[63:32];
                n_v[8+i]  = g[95:64];
                n_v[12+i] = g[127:96];
            end else begin
                g = blk3_pkg::g_mix(r_v[i], r_v[4+((i+1)%4)], r_v[8+((i+2)%4)],
                                    r_v[12+((i+3)%4)], r_m[8+2*i], r_m[9+2*i]);
                n_v[i]              = g[31:0];
                n_v[4+((i+1)%4)]    = g[63:32];
                n_v[8+((i+2)%4)]    = g[95:64];
                n_v[12+((i+3)%4)]   = g[127:96];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_rnd  <= '0;
            r_half <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_v    <= w_init_v;
                r_m    <= w_init_m;
                r_rnd  <= '0;
                r_half <= 1'b0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_v    <= n_v;
                r_half <= ~r_half;
                if (r_half) begin
                    r_m   <= blk3_pkg::permute(r_m);
                    r_rnd <= r_rnd + 1'b1;
                    if (r_rnd == blk3_pkg::LAST_ROUND) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_cv   <= blk3_pkg::IV;
            r_buf  <= '0;
            r_fill <= '0;
            r_bic  <= '0;
            r_ctr  <= '0;
            r_top  <= '0;
            r_ovf  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_word <= i_msg_word;
            end
            if (i_cmd.append) begin
                r_buf[r_fill[5:2]] <= r_buf[r_fill[5:2]] | w_byte_sh;
                r_word <= {8'h00, r_word[31:8]};
                r_fill <= r_fill + 1'b1;
            end
            if (i_cmd.commit_blk) begin
                if (r_bic == blk3_pkg::LAST_BLK) begin
                    r_res   <= w_result;
                    r_total <= r_ctr + 64'd1;
                    r_cv    <= blk3_pkg::IV;
                    r_bic   <= '0;
                end else begin
                    r_cv  <= w_result;
                    r_bic <= r_bic + 1'b1;
                end
                r_buf  <= '0;
                r_fill <= '0;
            end
            if (i_cmd.pop) begin
                r_top <= w_top_m1;
            end
            if (i_cmd.push) begin
                if (w_full) r_ovf <= 1'b1;
                else        r_top <= r_top + 1'b1;
                r_ctr <= r_ctr + 64'd1;
            end
            if (i_cmd.take_res) begin
                r_res <= w_result;
            end
            if (i_cmd.shift_total) begin
                r_total <= {1'b0, r_total[63:1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !w_full) begin
            r_stack[r_top[AW-1:0]] <= r_res;
        end
        if (i_cmd.pop) begin
            r_rd <= r_stack[w_top_m1[AW-1:0]];
        end
    end

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |-> !r_busy) else $error("compression started while busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("done held for more than one cycle");
    a_append_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.append |-> (r_fill < blk3_pkg::BLK_BYTES)) else $error("append into full block");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_top != '0)) else $error("pop from empty stack");
`endif

endmodule

/* src/blk3_ctrl.sv */
// Controller: sequences byte packing, block and parent compressions and digest output.
`timescale 1ns / 1ps
module blk3_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [2:0]       i_byte_count,
    input  logic             i_end_of_message,
    input  logic             i_out_ready,
    input  blk3_pkg::t_stat  i_stat,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output logic [1:0]       o_part_index,
    output logic             o_final_part,
    output blk3_pkg::t_cmd   o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_BYTE,
        S_BCMP,
        S_MCHK,
        S_MRD,
        S_MCMP,
        S_FCMP,
        S_FCHK,
        S_FRD,
        S_OUT
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_cnt, n_cnt;
    logic       r_last, n_last;
    logic [1:0] r_part, n_part;

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = (r_state == S_OUT);
    assign o_part_index = r_part;
    assign o_final_part = (r_part == blk3_pkg::LAST_PART);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_last  = r_last;
        n_part  = r_part;
        o_cmd   = '0;
        o_cmd.kind = blk3_pkg::K_FLUSH;
        o_cmd.part = r_part;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt   = (i_byte_count > blk3_pkg::MAX_BYTES) ? blk3_pkg::MAX_BYTES
                                                               : i_byte_count;
                    n_last  = i_end_of_message;
                    n_state = S_BYTE;
                end
            end
            S_BYTE: begin
                if (r_cnt == '0) begin
                    if (r_last) begin
                        o_cmd.start = 1'b1;
                        o_cmd.kind  = blk3_pkg::K_FINAL;
                        n_state     = S_FCMP;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else if (i_stat.fill_full) begin
                    // compress the full block only once another byte is known
                    o_cmd.start = 1'b1;
                    n_state     = S_BCMP;
                end else begin
                    o_cmd.append = 1'b1;
                    n_cnt        = r_cnt - 1'b1;
                end
            end
            S_BCMP: begin
                if (i_stat.done) begin
                    o_cmd.commit_blk = 1'b1;
                    n_state = i_stat.chunk_last_blk ? S_MCHK : S_BYTE;
                end
            end
            S_MCHK: begin
                if (i_stat.can_merge) begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_MRD;
                end else begin
                    o_cmd.push = 1'b1;
                    n_state    = S_BYTE;
                end
            end
            S_MRD: begin
                o_cmd.start = 1'b1;
                o_cmd.kind  = blk3_pkg::K_PARENT;
                n_state     = S_MCMP;
            end
            S_MCMP: begin
                if (i_stat.done) begin
                    o_cmd.take_res    = 1'b1;
                    o_cmd.shift_total = 1'b1;
                    n_state           = S_MCHK;
                end
            end
            S_FCMP: begin
                if (i_stat.done) begin
                    o_cmd.take_res = 1'b1;
                    n_state        = S_FCHK;
                end
            end
            S_FCHK: begin
                if (!i_stat.top_zero) begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_FRD;
                end else begin
                    n_part  = '0;
                    n_state = S_OUT;
                end
            end
            S_FRD: begin
                o_cmd.start = 1'b1;
                o_cmd.kind  = blk3_pkg::K_PARENT;
                o_cmd.root  = i_stat.top_zero;
                n_state     = S_FCMP;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    if (r_part == blk3_pkg::LAST_PART) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        n_part = r_part + 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_last  <= 1'b0;
            r_part  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_last  <= n_last;
            r_part  <= n_part;
        end
    end

endmodule
